>>> rtl/mpse_pkg.sv
// shared types and constants of the minimum projection signature engine
package mpse_pkg;

    localparam int CNT_W  = 7;
    localparam int VAL_W  = 32;
    localparam int COEF_W = 16;
    localparam int PROD_W = 48;
    localparam int SUM_W  = 54;
    localparam int MED_W  = 49;
    localparam int NM_W   = 56;
    localparam int SIG_W  = 64;
    localparam int CFG_W  = 7;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_TRAIN = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] CFG_PLANES = 2'd0;
    localparam logic [1:0] CFG_DIMS   = 2'd1;
    localparam logic [1:0] CFG_MEDIAN = 2'd2;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [2:0]              plane_index;
        logic [5:0]              dim_index;
        logic [5:0]              vector_index;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } in_item_t;

    typedef struct packed {
        logic [SIG_W-1:0] signature;
        logic [5:0]       vector_number;
        logic             is_query;
        logic             final_res;
    } out_item_t;

    typedef struct packed {
        logic                     en;
        logic [2:0]               plane;
        logic [5:0]               dim;
        logic signed [COEF_W-1:0] data;
    } coef_wr_t;

    typedef struct packed {
        logic             start;
        logic             use_median;
        logic [CNT_W-1:0] n;
    } eval_req_t;

endpackage

>>> rtl/mpse_min_unit.sv
// coefficient store and shared multiplier forming the minimum product over planes
module mpse_min_unit #(
    parameter int MAX_PLANES = 8,
    parameter int MAX_DIMS   = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mpse_pkg::coef_wr_t                coef_wr,
    input  logic                              start,
    input  logic [5:0]                        dim,
    input  logic signed [mpse_pkg::VAL_W-1:0] value,
    input  logic [mpse_pkg::CNT_W-1:0]        nplanes,
    output logic                              done,
    output logic signed [mpse_pkg::PROD_W-1:0] minimum
);
    import mpse_pkg::*;

    localparam int DEPTH = MAX_PLANES * MAX_DIMS;
    localparam int CA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [COEF_W-1:0] coef_mem [DEPTH];

    logic                      active_reg, active_next;
    logic [CNT_W-1:0]          iss_reg, iss_next;
    logic [CNT_W-1:0]          cmp_reg, cmp_next;
    logic [CNT_W-1:0]          np_reg;
    logic                      rd_vld_reg, mul_vld_reg, done_reg;
    logic signed [VAL_W-1:0]   val_reg;
    logic [5:0]                dim_reg;
    logic signed [COEF_W-1:0]  coef_q;
    logic signed [PROD_W-1:0]  prod_reg, best_reg;
    logic [CA_W-1:0]           wr_addr, rd_addr;
    logic                      issue, last_cmp;

    assign wr_addr  = CA_W'(coef_wr.plane) * CA_W'(MAX_DIMS) + CA_W'(coef_wr.dim);
    assign rd_addr  = CA_W'(iss_reg) * CA_W'(MAX_DIMS) + CA_W'(dim_reg);
    assign issue    = active_reg && (iss_reg < np_reg);
    assign last_cmp = mul_vld_reg && ((cmp_reg + CNT_W'(1)) == np_reg);

    always_comb
    begin
        active_next = active_reg;
        iss_next    = iss_reg;
        cmp_next    = cmp_reg;
        if (start)
        begin
            active_next = 1'b1;
            iss_next    = '0;
            cmp_next    = '0;
        end
        else
        begin
            if (issue)
                iss_next = iss_reg + CNT_W'(1);
            if (mul_vld_reg)
                cmp_next = cmp_reg + CNT_W'(1);
            if (last_cmp)
                active_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (coef_wr.en)
            coef_mem[wr_addr] <= coef_wr.data;
        coef_q <= coef_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            iss_reg     <= '0;
            cmp_reg     <= '0;
            np_reg      <= CNT_W'(1);
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            iss_reg     <= iss_next;
            cmp_reg     <= cmp_next;
            rd_vld_reg  <= issue;
            mul_vld_reg <= rd_vld_reg;
            done_reg    <= last_cmp;
            if (start)
                np_reg <= nplanes;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= value;
            dim_reg <= dim;
        end
        prod_reg <= PROD_W'(val_reg) * PROD_W'(coef_q);
        if (mul_vld_reg && ((cmp_reg == '0) || (prod_reg < best_reg)))
            best_reg <= prod_reg;
    end

    assign done    = done_reg;
    assign minimum = best_reg;

endmodule

>>> rtl/mpse_bit_eval.sv
// two stage threshold test of one minimum against mean or median
module mpse_bit_eval (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mpse_pkg::eval_req_t                req,
    input  logic signed [mpse_pkg::PROD_W-1:0] m,
    input  logic signed [mpse_pkg::SUM_W-1:0]  sum,
    input  logic signed [mpse_pkg::MED_W-1:0]  med,
    output logic                               done,
    output logic                               hit
);
    import mpse_pkg::*;

    logic                     s1_vld_reg, done_reg;
    logic signed [NM_W-1:0]   nm_reg;
    logic signed [MED_W-1:0]  m2_reg, med_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     um_reg, hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= req.start;
            done_reg   <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            // n times min for the mean test, doubled min for the median test
            nm_reg  <= NM_W'($signed({1'b0, req.n})) * NM_W'(m);
            m2_reg  <= MED_W'(m) <<< 1;
            sum_reg <= sum;
            med_reg <= med;
            um_reg  <= req.use_median;
        end
        if (s1_vld_reg)
            hit_reg <= um_reg ? (m2_reg >= med_reg) : (nm_reg > NM_W'(sum_reg));
    end

    assign done = done_reg;
    assign hit  = hit_reg;

endmodule

>>> rtl/min_projection_signature_engine_core.sv
// top level: sequencer, minimum and threshold stores, output register
// element: training or query items take the minimum over the planes in use
// training end: per dimension, rank counting over the minimum store,
// then a threshold test per signature bit, one training item out per vector
// last query element: result loaded in S_QOUT; output stalls hold the sequencer
// reset clears control, sets 8 planes / 64 dims / mean, and makes all thresholds read zero
module min_projection_signature_engine_core #(
    parameter int MAX_PLANES  = 8,
    parameter int MAX_DIMS    = 64,
    parameter int MAX_VECTORS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  mpse_pkg::in_item_t            in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output mpse_pkg::out_item_t           out_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [mpse_pkg::CFG_W-1:0]    cfg_data
);
    import mpse_pkg::*;

    localparam int MDEPTH = MAX_VECTORS * MAX_DIMS;
    localparam int MA_W   = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
    localparam int DA_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    // sequencer states, one-hot
    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_MIN      = 15'b000000000000010,
        S_QRD      = 15'b000000000000100,
        S_QLD      = 15'b000000000001000,
        S_QWAIT    = 15'b000000000010000,
        S_QOUT     = 15'b000000000100000,
        S_ST_CAND  = 15'b000000001000000,
        S_ST_CLOAD = 15'b000000010000000,
        S_ST_SWEEP = 15'b000000100000000,
        S_ST_CDONE = 15'b000001000000000,
        S_ST_WR    = 15'b000010000000000,
        S_EM_RD    = 15'b000100000000000,
        S_EM_LD    = 15'b001000000000000,
        S_EM_WAIT  = 15'b010000000000000,
        S_EM_OUT   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [3:0]       planes_reg;
    logic [6:0]       dims_reg;
    logic             use_median_reg;
    logic [CNT_W-1:0] np, nd;

    // stores
    logic signed [PROD_W-1:0] min_mem [MDEPTH];
    logic signed [SUM_W-1:0]  sum_mem [MAX_DIMS];
    logic signed [MED_W-1:0]  med_mem [MAX_DIMS];
    logic [MAX_DIMS-1:0]      thr_vld_reg;
    logic signed [PROD_W-1:0] min_q;
    logic signed [SUM_W-1:0]  thr_sum_q;
    logic signed [MED_W-1:0]  thr_med_q;
    logic                     thr_vq_reg;
    logic [MA_W-1:0]          mr_addr, mw_addr;
    logic [CNT_W-1:0]         mr_row;
    logic                     mw_en, tw_en;
    logic [DA_W-1:0]          tr_addr, tw_addr;

    // sequencer registers
    in_item_t                 item_reg;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [CNT_W-1:0]         j_reg, j_next, ci_reg, ci_next, k_reg, k_next, i_reg, i_next;
    logic [CNT_W-1:0]         lt_reg, lt_next, le_reg, le_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic signed [PROD_W-1:0] cand_reg, cand_next, v0_reg, v0_next, v1_reg, v1_next;
    logic signed [PROD_W-1:0] m_reg, m_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [SIG_W-1:0]         qbits_reg, qbits_next, sig_reg, sig_next, dmask;
    logic [CNT_W-1:0]         r0, r1;

    // output register
    logic                     out_valid_reg, out_load, out_free;
    out_item_t                out_item_reg, out_item_next;

    // handshakes and unit links
    logic                     in_acc, vec_ok, dim_ok, min_start, min_done;
    logic signed [PROD_W-1:0] min_val;
    coef_wr_t                 coef_wr;
    eval_req_t                ev_req;
    logic                     ev_done, ev_hit;
    logic signed [PROD_W-1:0] ev_m;
    logic signed [SUM_W-1:0]  ev_sum;
    logic signed [MED_W-1:0]  ev_med;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // out of range register values clamp to the legal span
    always_comb
    begin
        if (planes_reg == 4'd0)
            np = CNT_W'(1);
        else if (CNT_W'(planes_reg) > CNT_W'(MAX_PLANES))
            np = CNT_W'(MAX_PLANES);
        else
            np = CNT_W'(planes_reg);
        if (dims_reg == 7'd0)
            nd = CNT_W'(1);
        else if (CNT_W'(dims_reg) > CNT_W'(MAX_DIMS))
            nd = CNT_W'(MAX_DIMS);
        else
            nd = CNT_W'(dims_reg);
    end

    always_comb
    begin
        for (int b = 0; b < SIG_W; b++)
            dmask[b] = (CNT_W'(b) < nd);
    end

    assign vec_ok = CNT_W'(in_item.vector_index) < CNT_W'(MAX_VECTORS);
    assign dim_ok = CNT_W'(in_item.dim_index) < nd;
    assign min_start = in_acc && dim_ok &&
                       (((in_item.cmd == CMD_TRAIN) && vec_ok) || (in_item.cmd == CMD_QUERY));

    assign coef_wr.en    = in_acc && (in_item.cmd == CMD_LOAD) &&
                           (CNT_W'(in_item.plane_index) < CNT_W'(MAX_PLANES)) &&
                           (CNT_W'(in_item.dim_index) < CNT_W'(MAX_DIMS));
    assign coef_wr.plane = in_item.plane_index;
    assign coef_wr.dim   = in_item.dim_index;
    assign coef_wr.data  = in_item.value[COEF_W-1:0];

    mpse_min_unit #(
        .MAX_PLANES (MAX_PLANES),
        .MAX_DIMS   (MAX_DIMS)
    ) u_min (
        .clk     (clk),
        .rst_n   (rst_n),
        .coef_wr (coef_wr),
        .start   (min_start),
        .dim     (in_item.dim_index),
        .value   (in_item.value),
        .nplanes (np),
        .done    (min_done),
        .minimum (min_val)
    );

    // threshold test, shared by training signatures and queries
    assign ev_req.start      = (state_reg == S_EM_LD) || (state_reg == S_QLD);
    assign ev_req.use_median = use_median_reg;
    assign ev_req.n          = (count_reg == '0) ? CNT_W'(1) : count_reg;
    assign ev_m              = (state_reg == S_QLD) ? m_reg : min_q;
    assign ev_sum            = thr_vq_reg ? thr_sum_q : '0;
    assign ev_med            = thr_vq_reg ? thr_med_q : '0;

    mpse_bit_eval u_eval (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ev_req),
        .m     (ev_m),
        .sum   (ev_sum),
        .med   (ev_med),
        .done  (ev_done),
        .hit   (ev_hit)
    );

    // minimum store addressing: candidate, sweep or emission row
    always_comb
    begin
        unique case (state_reg)
            S_ST_CAND:  mr_row = ci_reg;
            S_ST_SWEEP: mr_row = k_reg;
            default:    mr_row = i_reg;
        endcase
    end

    assign mr_addr = MA_W'(mr_row) * MA_W'(MAX_DIMS) + MA_W'(j_reg);
    assign mw_addr = MA_W'(item_reg.vector_index) * MA_W'(MAX_DIMS) + MA_W'(item_reg.dim_index);
    assign mw_en   = (state_reg == S_MIN) && min_done && (item_reg.cmd == CMD_TRAIN);
    assign tr_addr = (state_reg == S_QRD) ? DA_W'(item_reg.dim_index) : DA_W'(j_reg);
    assign tw_addr = DA_W'(j_reg);
    assign tw_en   = (state_reg == S_ST_WR);

    // ranks of the two middle values; equal for an odd count
    assign r0 = (n_reg - CNT_W'(1)) >> 1;
    assign r1 = n_reg >> 1;

    always_ff @(posedge clk)
    begin
        if (mw_en)
            min_mem[mw_addr] <= min_val;
        min_q <= min_mem[mr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (tw_en)
        begin
            sum_mem[tw_addr] <= sum_reg;
            med_mem[tw_addr] <= MED_W'(v0_reg) + MED_W'(v1_reg);
        end
        thr_sum_q <= sum_mem[tr_addr];
        thr_med_q <= med_mem[tr_addr];
    end

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        j_next        = j_reg;
        ci_next       = ci_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        lt_next       = lt_reg;
        le_next       = le_reg;
        count_next    = count_reg;
        rd_vld_next   = 1'b0;
        cand_next     = cand_reg;
        v0_next       = v0_reg;
        v1_next       = v1_reg;
        m_next        = m_reg;
        sum_next      = sum_reg;
        qbits_next    = qbits_reg;
        sig_next      = sig_reg;
        out_load      = 1'b0;
        out_item_next = out_item_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    n_next = CNT_W'(in_item.vector_index) + CNT_W'(1);
                    if (min_start)
                        state_next = S_MIN;
                    else if ((in_item.cmd == CMD_TRAIN) && vec_ok && in_item.last)
                    begin
                        j_next     = '0;
                        ci_next    = '0;
                        sum_next   = '0;
                        state_next = S_ST_CAND;
                    end
                    else if ((in_item.cmd == CMD_QUERY) && in_item.last)
                        state_next = S_QOUT;
                end
            end
            S_MIN:
            begin
                if (min_done)
                begin
                    if (item_reg.cmd == CMD_TRAIN)
                    begin
                        if (item_reg.last)
                        begin
                            j_next     = '0;
                            ci_next    = '0;
                            sum_next   = '0;
                            state_next = S_ST_CAND;
                        end
                        else
                            state_next = S_IDLE;
                    end
                    else
                    begin
                        m_next     = min_val;
                        state_next = S_QRD;
                    end
                end
            end
            S_QRD:
                state_next = S_QLD;
            S_QLD:
                state_next = S_QWAIT;
            S_QWAIT:
            begin
                if (ev_done)
                begin
                    qbits_next[item_reg.dim_index] = ev_hit;
                    state_next = item_reg.last ? S_QOUT : S_IDLE;
                end
            end
            S_QOUT:
            begin
                if (out_free)
                begin
                    out_load                    = 1'b1;
                    out_item_next.signature     = qbits_reg & dmask;
                    out_item_next.vector_number = '0;
                    out_item_next.is_query      = 1'b1;
                    out_item_next.final_res     = 1'b1;
                    qbits_next                  = '0;
                    state_next                  = S_IDLE;
                end
            end
            S_ST_CAND:
                state_next = S_ST_CLOAD;
            S_ST_CLOAD:
            begin
                cand_next  = min_q;
                k_next     = '0;
                lt_next    = '0;
                le_next    = '0;
                state_next = S_ST_SWEEP;
            end
            S_ST_SWEEP:
            begin
                // reads issued back to back, each compared in the cycle after its issue
                if (k_reg < n_reg)
                begin
                    k_next      = k_reg + CNT_W'(1);
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (min_q < cand_reg)
                        lt_next = lt_reg + CNT_W'(1);
                    if (min_q <= cand_reg)
                        le_next = le_reg + CNT_W'(1);
                    if (ci_reg == '0)
                        sum_next = sum_reg + SUM_W'(min_q);
                end
                if ((k_reg == n_reg) && !rd_vld_reg)
                    state_next = S_ST_CDONE;
            end
            S_ST_CDONE:
            begin
                // candidate holds rank r when lt <= r < le
                if ((lt_reg <= r0) && (r0 < le_reg))
                    v0_next = cand_reg;
                if ((lt_reg <= r1) && (r1 < le_reg))
                    v1_next = cand_reg;
                ci_next    = ci_reg + CNT_W'(1);
                state_next = ((ci_reg + CNT_W'(1)) == n_reg) ? S_ST_WR : S_ST_CAND;
            end
            S_ST_WR:
            begin
                ci_next  = '0;
                sum_next = '0;
                if ((j_reg + CNT_W'(1)) == nd)
                begin
                    count_next = n_reg;
                    i_next     = '0;
                    j_next     = '0;
                    sig_next   = '0;
                    state_next = S_EM_RD;
                end
                else
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_ST_CAND;
                end
            end
            S_EM_RD:
                state_next = S_EM_LD;
            S_EM_LD:
                state_next = S_EM_WAIT;
            S_EM_WAIT:
            begin
                if (ev_done)
                begin
                    sig_next[j_reg[5:0]] = ev_hit;
                    if ((j_reg + CNT_W'(1)) == nd)
                        state_next = S_EM_OUT;
                    else
                    begin
                        j_next     = j_reg + CNT_W'(1);
                        state_next = S_EM_RD;
                    end
                end
            end
            S_EM_OUT:
            begin
                if (out_free)
                begin
                    out_load                    = 1'b1;
                    out_item_next.signature     = sig_reg;
                    out_item_next.vector_number = i_reg[5:0];
                    out_item_next.is_query      = 1'b0;
                    out_item_next.final_res     = ((i_reg + CNT_W'(1)) == n_reg);
                    if ((i_reg + CNT_W'(1)) == n_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        j_next     = '0;
                        sig_next   = '0;
                        state_next = S_EM_RD;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            planes_reg     <= 4'd8;
            dims_reg       <= 7'd64;
            use_median_reg <= 1'b0;
            thr_vld_reg    <= '0;
            thr_vq_reg     <= 1'b0;
            count_reg      <= '0;
            qbits_reg      <= '0;
            out_valid_reg  <= 1'b0;
            n_reg          <= CNT_W'(1);
            j_reg          <= '0;
            ci_reg         <= '0;
            k_reg          <= '0;
            i_reg          <= '0;
            lt_reg         <= '0;
            le_reg         <= '0;
            rd_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            qbits_reg     <= qbits_next;
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
            n_reg         <= n_next;
            j_reg         <= j_next;
            ci_reg        <= ci_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            lt_reg        <= lt_next;
            le_reg        <= le_next;
            rd_vld_reg    <= rd_vld_next;
            thr_vq_reg    <= thr_vld_reg[tr_addr];
            if (tw_en)
                thr_vld_reg[tw_addr] <= 1'b1;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_PLANES: planes_reg     <= cfg_data[3:0];
                    CFG_DIMS:   dims_reg       <= cfg_data[6:0];
                    CFG_MEDIAN: use_median_reg <= cfg_data[0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            item_reg <= in_item;
        cand_reg     <= cand_next;
        v0_reg       <= v0_next;
        v1_reg       <= v1_next;
        m_reg        <= m_next;
        sum_reg      <= sum_next;
        sig_reg      <= sig_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef ASSERT_OFF
    a_min_done_in_min: assert property (@(posedge clk) disable iff (!rst_n)
        min_done |-> (state_reg == S_MIN))
        else $error("element minimum finished outside its wait state");

    a_eval_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        ev_done |-> ((state_reg == S_EM_WAIT) || (state_reg == S_QWAIT)))
        else $error("threshold test finished with nobody waiting");

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output register loaded over an untaken item");

    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ST_SWEEP) |-> (k_reg <= n_reg))
        else $error("rank sweep ran past the training count");

    a_empty_query_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_item.cmd == CMD_QUERY) && in_item.last && !dim_ok)
        |=> (state_reg == S_QOUT))
        else $error("query last mark without data not honoured");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench of the minimum projection signature engine
module tb_top;
    import mpse_pkg::*;

    localparam int N_PLANES      = 8;
    localparam int N_DIMS        = 64;
    localparam int N_VECS        = 64;
    // dimensions covered by random coefficients, and the widest random dims setting
    localparam int RND_DIMS      = 8;
    // cycles allowed for an element with no result to finish before a register write
    localparam int SETTLE_CYCLES = 80;
    // the command code that the block ignores
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    in_item_t            in_item;
    logic                out_valid;
    logic                out_stall;
    out_item_t           out_item;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    min_projection_signature_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor state: our own copy of the stores and registers
    // ---------------------------------------------------------------
    logic signed [COEF_W-1:0] coef_mem  [N_PLANES*N_DIMS];
    logic signed [PROD_W-1:0] min_mem   [N_VECS*N_DIMS];
    logic signed [SUM_W-1:0]  sum_thr   [N_DIMS];
    logic signed [MED_W-1:0]  med2_thr  [N_DIMS];
    int unsigned              trained_n;
    logic [SIG_W-1:0]         qry_bits;
    int unsigned              planes_reg;
    int unsigned              dims_reg;
    bit                       median_reg;

    // signatures still owed by the block, oldest first
    out_item_t pending_sigs[$];
    out_item_t want_sig;
    int        errors;
    int        items_sent;
    int        send_idle;
    int        recv_idle;

    // a directed row is either a register write or an item, sometimes with its result typed in
    typedef struct {
        bit               is_cfg;
        logic [1:0]       idx;
        logic [CFG_W-1:0] data;
        in_item_t         it;
        bit               typed;
        out_item_t        want;
    } row_t;

    row_t rows[$];

    // add a signature at the tail of the owed list
    function automatic void owe_sig(out_item_t r);
        pending_sigs = {pending_sigs, r};
    endfunction

    function automatic int unsigned act_planes();
        if (planes_reg == 0) return 1;
        return (planes_reg > N_PLANES) ? N_PLANES : planes_reg;
    endfunction

    function automatic int unsigned act_dims();
        if (dims_reg == 0) return 1;
        return (dims_reg > N_DIMS) ? N_DIMS : dims_reg;
    endfunction

    // smallest product over the planes in use
    function automatic longint proj_min(int unsigned d, longint v);
        longint best;
        longint prod;
        best = v * longint'(coef_mem[d]);
        for (int unsigned p = 1; p < act_planes(); p++)
        begin
            prod = v * longint'(coef_mem[p*N_DIMS + d]);
            if (prod < best) best = prod;
        end
        return best;
    endfunction

    // mean test done as n*min > sum, median test as 2*min >= doubled median
    function automatic bit over_thr(int unsigned d, longint m);
        longint cnt;
        if (median_reg) return (2 * m) >= longint'(med2_thr[d]);
        cnt = (trained_n != 0) ? longint'(trained_n) : 64'sd1;
        return (cnt * m) > longint'(sum_thr[d]);
    endfunction

    task automatic model_reset();
        for (int j = 0; j < N_DIMS; j++)
        begin
            sum_thr[j]  = '0;
            med2_thr[j] = '0;
        end
        trained_n  = 0;
        qry_bits   = '0;
        planes_reg = 8;
        dims_reg   = 64;
        median_reg = 1'b0;
    endtask

    // end of a training set: thresholds per dimension, then one signature per vector
    task automatic close_training(int unsigned n, bit record);
        longint      col[N_VECS];
        longint      s;
        longint      x;
        int          k;
        int unsigned nd;
        out_item_t   r;
        nd = act_dims();
        for (int unsigned j = 0; j < nd; j++)
        begin
            s = 0;
            for (int unsigned i = 0; i < n; i++)
            begin
                x = longint'(min_mem[i*N_DIMS + j]);
                s += x;
                k = i;
                while (k > 0 && col[k-1] > x)
                begin
                    col[k] = col[k-1];
                    k--;
                end
                col[k] = x;
            end
            sum_thr[j] = SUM_W'(s);
            if (n % 2) med2_thr[j] = MED_W'(2 * col[n/2]);
            else       med2_thr[j] = MED_W'(col[n/2] + col[n/2 - 1]);
        end
        trained_n = n;
        for (int unsigned i = 0; i < n; i++)
        begin
            r = '0;
            for (int unsigned j = 0; j < nd; j++)
                if (over_thr(j, longint'(min_mem[i*N_DIMS + j]))) r.signature[j] = 1'b1;
            r.vector_number = 6'(i);
            r.is_query      = 1'b0;
            r.final_res     = (i == n - 1);
            if (record) owe_sig(r);
        end
    endtask

    // predict the effect of one accepted item
    task automatic model_accept(in_item_t it, bit record);
        int unsigned nd;
        longint      v;
        out_item_t   r;
        nd = act_dims();
        v  = longint'($signed(it.value));
        case (it.cmd)
            CMD_LOAD:
                coef_mem[it.plane_index*N_DIMS + it.dim_index] = it.value[15:0];
            CMD_TRAIN:
            begin
                if (it.dim_index < nd)
                    min_mem[it.vector_index*N_DIMS + it.dim_index] =
                        PROD_W'(proj_min(it.dim_index, v));
                if (it.last) close_training(it.vector_index + 1, record);
            end
            CMD_QUERY:
            begin
                if (it.dim_index < nd)
                    qry_bits[it.dim_index] = over_thr(it.dim_index, proj_min(it.dim_index, v));
                if (it.last)
                begin
                    r.signature     = qry_bits & ((nd >= 64) ? '1 : ((64'd1 << nd) - 1));
                    r.vector_number = '0;
                    r.is_query      = 1'b1;
                    r.final_res     = 1'b1;
                    if (record) owe_sig(r);
                    qry_bits = '0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("tb_top: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // ---------------------------------------------------------------
    // result side: random stall and in-order comparison
    // ---------------------------------------------------------------
    always @(posedge clk)
        out_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_sigs.size() == 0)
                report_mismatch("unexpected result", out_item.signature, '0);
            else
            begin
                want_sig = pending_sigs.pop_front();
                if (out_item.signature !== want_sig.signature)
                    report_mismatch("signature", out_item.signature, want_sig.signature);
                if (out_item.vector_number !== want_sig.vector_number)
                    report_mismatch("vector_number", out_item.vector_number,
                                    want_sig.vector_number);
                if (out_item.is_query !== want_sig.is_query)
                    report_mismatch("is_query", out_item.is_query, want_sig.is_query);
                if (out_item.final_res !== want_sig.final_res)
                    report_mismatch("final_res", out_item.final_res, want_sig.final_res);
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus side
    // ---------------------------------------------------------------
    function automatic in_item_t make_item(logic [1:0] cmd, int plane, int dim, int vec,
                                           logic [31:0] value, bit last);
        in_item_t it;
        it.cmd          = cmd;
        it.plane_index  = 3'(plane);
        it.dim_index    = 6'(dim);
        it.vector_index = 6'(vec);
        it.value        = value;
        it.last         = last;
        return it;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return 32'($urandom_range(2000)) - 32'd1000;
            default: return $urandom;
        endcase
    endfunction

    // one item through the handshake, sender gaps first; called at a rising edge
    task automatic send_item(in_item_t it, bit record);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        model_accept(it, record);
        if (it.cmd != CMD_UNUSED) items_sent++;
    endtask

    // register write once the block has drained
    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
        in_valid <= 1'b0;
        while (pending_sigs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PLANES: planes_reg = data & 7'h0F;
            CFG_DIMS:   dims_reg   = data & 7'h7F;
            CFG_MEDIAN: median_reg = data[0];
            default: ;
        endcase
    endtask

    // well-formed training set: every vector and dimension in use, last on the final one or on a trailing element
    task automatic train_run(int unsigned n);
        int unsigned nd;
        bit          tail;
        nd   = act_dims();
        tail = (nd < N_DIMS) && ($urandom_range(3) == 0);
        for (int unsigned i = 0; i < n; i++)
            for (int unsigned j = 0; j < nd; j++)
                send_item(make_item(CMD_TRAIN, $urandom_range(7), j, i, pick_value(),
                                    (i == n - 1) && (j == nd - 1) && !tail), 1'b1);
        // last mark carried by an element outside the dimensions in use
        if (tail)
            send_item(make_item(CMD_TRAIN, $urandom_range(7), $urandom_range(N_DIMS - 1, nd),
                                n - 1, pick_value(), 1'b1), 1'b1);
    endtask

    task automatic query_run();
        int unsigned nd;
        int unsigned cnt;
        int unsigned d;
        nd  = act_dims();
        cnt = $urandom_range(nd + 1, 1);
        for (int unsigned t = 0; t < cnt; t++)
        begin
            d = ($urandom_range(3) == 0) ? $urandom_range(N_DIMS - 1) : $urandom_range(nd - 1);
            send_item(make_item(CMD_QUERY, $urandom_range(7), d, $urandom_range(63),
                                pick_value(), t == cnt - 1), 1'b1);
        end
    endtask

    // dims stay within the dimensions that hold random coefficients
    task automatic random_cfg();
        case ($urandom_range(2))
            0: write_reg(CFG_PLANES, ($urandom_range(4) == 0) ? 7'($urandom_range(127))
                                                              : 7'($urandom_range(8, 1)));
            1: write_reg(CFG_DIMS, 7'($urandom_range(RND_DIMS)));
            default: write_reg(CFG_MEDIAN, 7'($urandom_range(127)));
        endcase
    endtask

    task automatic run_phase(int s_idle, int r_idle, int target);
        int start;
        int pick;
        send_idle = s_idle;
        recv_idle = r_idle;
        repeat (3) random_cfg();
        start = items_sent;
        while (items_sent - start < target)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                train_run((act_dims() > 16) ? $urandom_range(2, 1) : $urandom_range(5, 1));
            else if (pick < 62)
                query_run();
            else if (pick < 72)
                repeat (3) send_item(make_item(CMD_LOAD, $urandom_range(7),
                                     $urandom_range(RND_DIMS - 1), $urandom_range(63),
                                     $urandom, $urandom_range(1)), 1'b1);
            else if (pick < 82)
                // stray training element: overwrites a minimum if its dimension is in use, no last mark
                send_item(make_item(CMD_TRAIN, $urandom_range(7), $urandom_range(63),
                                    $urandom_range(63), pick_value(), 1'b0), 1'b1);
            else if (pick < 88)
                send_item(make_item(CMD_UNUSED, $urandom_range(7), $urandom_range(63),
                                    $urandom_range(63), $urandom, $urandom_range(1)), 1'b1);
            else if (pick < 92)
            begin
                // hold off until every owed signature is out
                in_valid <= 1'b0;
                while (pending_sigs.size() != 0) @(posedge clk);
                @(posedge clk);
            end
            else
                random_cfg();
        end
    endtask

    function automatic row_t item_row(in_item_t it);
        row_t r;
        r        = '{default: '0};
        r.it     = it;
        return r;
    endfunction

    function automatic row_t typed_row(in_item_t it, logic [SIG_W-1:0] sig);
        row_t r;
        r       = '{default: '0};
        r.it    = it;
        r.typed = 1'b1;
        r.want  = '{signature: sig, vector_number: '0, is_query: 1'b1, final_res: 1'b1};
        return r;
    endfunction

    function automatic row_t cfg_row(logic [1:0] idx, logic [CFG_W-1:0] data);
        row_t r;
        r        = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    initial
    begin
        in_valid   = 1'b0;
        in_item    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_PLANES;
        cfg_data   = '0;
        send_idle  = 0;
        recv_idle  = 0;
        errors     = 0;
        items_sent = 0;
        rst_n      = 1'b0;
        model_reset();

        // directed rows, written against unit coefficients and the reset settings
        rows = {
            // no training yet: mean mode tests min > 0
            typed_row(make_item(CMD_QUERY, 0, 0, 0, 32'd5, 1'b1), 64'h1),
            typed_row(make_item(CMD_QUERY, 0, 0, 0, -32'sd3, 1'b1), 64'h0),
            item_row(make_item(CMD_QUERY, 0, 1, 0, 32'd0, 1'b0)),
            typed_row(make_item(CMD_QUERY, 0, 0, 0, 32'h7FFF_FFFF, 1'b1), 64'h1),
            // unknown command gives nothing
            item_row(make_item(CMD_UNUSED, 7, 63, 63, 32'hFFFF_FFFF, 1'b1)),
            // coefficient extremes, upper half of the value ignored
            item_row(make_item(CMD_LOAD, 7, 63, 0, 32'h0000_7FFF, 1'b0)),
            item_row(make_item(CMD_LOAD, 0, 63, 0, 32'hFFFF_8000, 1'b1)),
            item_row(make_item(CMD_QUERY, 0, 63, 0, 32'h8000_0000, 1'b1)),
            item_row(make_item(CMD_QUERY, 0, 63, 0, 32'h7FFF_FFFF, 1'b1)),
            cfg_row(CFG_DIMS, 7'd2),
            cfg_row(CFG_PLANES, 7'd1),
            // two vectors, last mark on a dimension outside those in use
            item_row(make_item(CMD_TRAIN, 0, 0, 0, 32'd10, 1'b0)),
            item_row(make_item(CMD_TRAIN, 0, 1, 0, 32'd20, 1'b0)),
            item_row(make_item(CMD_TRAIN, 0, 0, 1, 32'd30, 1'b0)),
            item_row(make_item(CMD_TRAIN, 0, 1, 1, -32'sd4, 1'b0)),
            item_row(make_item(CMD_TRAIN, 0, 5, 1, 32'd0, 1'b1)),
            cfg_row(CFG_MEDIAN, 7'd1),
            item_row(make_item(CMD_QUERY, 0, 0, 0, 32'd20, 1'b0)),
            item_row(make_item(CMD_QUERY, 0, 1, 0, 32'd8, 1'b1)),
            // out-of-range registers clamp
            cfg_row(CFG_PLANES, 7'd0),
            cfg_row(CFG_DIMS, 7'd0),
            item_row(make_item(CMD_QUERY, 0, 0, 0, -32'sd1, 1'b1)),
            cfg_row(CFG_PLANES, 7'd15),
            cfg_row(CFG_DIMS, 7'd127),
            cfg_row(CFG_MEDIAN, 7'd0),
            item_row(make_item(CMD_QUERY, 0, 40, 0, 32'h0001_2345, 1'b1))
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unit coefficients on every plane of the dimensions that the directed rows read
        for (int p = 0; p < N_PLANES; p++)
            for (int d = 0; d < N_DIMS; d++)
                if (d == 0 || d == 1 || d == 40 || d == 63)
                    send_item(make_item(CMD_LOAD, p, d, 0, 32'h0000_0001, 1'b0), 1'b1);

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
                write_reg(rows[i].idx, rows[i].data);
            else
            begin
                send_item(rows[i].it, !rows[i].typed);
                if (rows[i].typed) owe_sig(rows[i].want);
            end
        end

        // random coefficients on every plane of the dimensions that the random part uses
        write_reg(CFG_DIMS, 7'(RND_DIMS));
        send_idle = 9;
        recv_idle = 45;
        for (int p = 0; p < N_PLANES; p++)
            for (int d = 0; d < RND_DIMS; d++)
                send_item(make_item(CMD_LOAD, p, d, $urandom_range(63), $urandom,
                                    $urandom_range(1)), 1'b1);

        run_phase(9, 45, 30);
        run_phase(45, 9, 30);

        // largest training set: every vector number, one signature each
        send_idle = 0;
        recv_idle = 0;
        write_reg(CFG_DIMS, 7'd1);
        train_run(N_VECS);
        run_phase(0, 0, 30);

        in_valid <= 1'b0;
        while (pending_sigs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending_sigs.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // watchdog, well beyond the slowest correct run
    initial
    begin
        #40_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
